// File: rtl/etmb_pkg.sv
// shared constants and types for the euler trs matrix builder
`default_nettype none

package etmb_pkg;

    localparam int CORDIC_STEPS = 16;
    // angle capture, one stage per cordic step, then round and quadrant fix
    localparam int CORDIC_DEPTH = CORDIC_STEPS + 2;
    // first stage after the cordic
    localparam int PROD_STAGE   = CORDIC_DEPTH;
    // products, triple products, sums, scale products, round and saturate
    localparam int NSTAGE       = CORDIC_DEPTH + 5;

    localparam int CW = 34;  // cordic datapath width, q2.30 plus headroom
    localparam int TW = 17;  // trig word, q1.15 with room for +1.0

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [TW-1:0] ONE_Q15     = 17'sd32768;
    localparam logic signed [23:0]   OUT_MAX     = 24'sd8388607;
    localparam logic signed [23:0]   OUT_MIN     = -24'sd8388608;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [23:0] scale_x;
        logic signed [23:0] scale_y;
        logic signed [23:0] scale_z;
    } t_side;

endpackage

`default_nettype wire

// File: rtl/etmb_cordic.sv
// pipelined rotation-mode cordic giving sine and cosine of a binary angle
`default_nettype none

module etmb_cordic (
    input  wire logic                                i_clk,
    input  wire logic [etmb_pkg::CORDIC_DEPTH-1:0]   i_en,
    input  wire logic [15:0]                         i_angle,
    output logic signed [etmb_pkg::TW-1:0]           o_sin,
    output logic signed [etmb_pkg::TW-1:0]           o_cos
);

    logic signed [etmb_pkg::CW-1:0] r_x [0:etmb_pkg::CORDIC_STEPS];
    logic signed [etmb_pkg::CW-1:0] r_y [0:etmb_pkg::CORDIC_STEPS];
    logic signed [etmb_pkg::CW-1:0] r_z [0:etmb_pkg::CORDIC_STEPS];
    logic [1:0]                     r_quad [0:etmb_pkg::CORDIC_STEPS];
    logic                           r_zero [0:etmb_pkg::CORDIC_STEPS];
    logic signed [etmb_pkg::TW-1:0] r_sin;
    logic signed [etmb_pkg::TW-1:0] r_cos;

    logic signed [etmb_pkg::CW-1:0] n_xr;
    logic signed [etmb_pkg::CW-1:0] n_yr;
    logic signed [etmb_pkg::CW-16:0] n_xs;
    logic signed [etmb_pkg::CW-16:0] n_ys;
    logic signed [etmb_pkg::TW-1:0] n_c;
    logic signed [etmb_pkg::TW-1:0] n_s;
    logic signed [etmb_pkg::TW-1:0] n_sin;
    logic signed [etmb_pkg::TW-1:0] n_cos;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0]    <= etmb_pkg::CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= $signed({4'b0, i_angle[13:0], 16'b0});
            r_quad[0] <= i_angle[15:14];
            r_zero[0] <= (i_angle[13:0] == 14'd0);
        end
    end

    for (genvar k = 1; k <= etmb_pkg::CORDIC_STEPS; k++) begin : g_step
        logic signed [etmb_pkg::CW-1:0] w_dx;
        logic signed [etmb_pkg::CW-1:0] w_dy;
        logic signed [etmb_pkg::CW-1:0] w_at;
        assign w_dx = r_x[k-1] >>> (k-1);
        assign w_dy = r_y[k-1] >>> (k-1);
        assign w_at = $signed({2'b0, etmb_pkg::ATAN_TURNS[k-1]});
        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                if (!r_z[k-1][etmb_pkg::CW-1]) begin
                    r_x[k] <= r_x[k-1] - w_dy;
                    r_y[k] <= r_y[k-1] + w_dx;
                    r_z[k] <= r_z[k-1] - w_at;
                end else begin
                    r_x[k] <= r_x[k-1] + w_dy;
                    r_y[k] <= r_y[k-1] - w_dx;
                    r_z[k] <= r_z[k-1] + w_at;
                end
                r_quad[k] <= r_quad[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    // round to q1.15, clamp to +-1, then fold in the quadrant
    always_comb begin
        n_xr = r_x[etmb_pkg::CORDIC_STEPS] + 34'sd16384;
        n_yr = r_y[etmb_pkg::CORDIC_STEPS] + 34'sd16384;
        n_xs = n_xr[etmb_pkg::CW-1:15];
        n_ys = n_yr[etmb_pkg::CW-1:15];
        if (n_xs > 19'sd32768) begin
            n_c = etmb_pkg::ONE_Q15;
        end else if (n_xs < -19'sd32768) begin
            n_c = -etmb_pkg::ONE_Q15;
        end else begin
            n_c = n_xs[etmb_pkg::TW-1:0];
        end
        if (n_ys > 19'sd32768) begin
            n_s = etmb_pkg::ONE_Q15;
        end else if (n_ys < -19'sd32768) begin
            n_s = -etmb_pkg::ONE_Q15;
        end else begin
            n_s = n_ys[etmb_pkg::TW-1:0];
        end
        if (r_zero[etmb_pkg::CORDIC_STEPS]) begin
            n_s = '0;
            n_c = etmb_pkg::ONE_Q15;
        end
        case (r_quad[etmb_pkg::CORDIC_STEPS])
            2'd0: begin
                n_sin = n_s;
                n_cos = n_c;
            end
            2'd1: begin
                n_sin = n_c;
                n_cos = -n_s;
            end
            2'd2: begin
                n_sin = -n_s;
                n_cos = -n_c;
            end
            default: begin
                n_sin = -n_c;
                n_cos = n_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[etmb_pkg::CORDIC_DEPTH-1]) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

`default_nettype wire

// File: rtl/euler_trs_matrix_builder.sv
// top level: trs model matrix from position, euler angles and scale
`default_nettype none

// Builds M = T * Rz * Ry * Rx * S for one transform per word. Fully pipelined:
// a new word can enter every cycle while o_stall is low, and its result reaches
// the outputs through 23 register stages: 18 of sine/cosine cordic, then
// product, triple product, sum and round, scale product, and round and
// saturate into the output register.
// Stall from downstream only holds the stages that are full, so bubbles in
// the pipe are squeezed out before o_stall is raised. Translation passes
// straight through; matrix entries saturate to the q8.16 range.
module euler_trs_matrix_builder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic [15:0]        i_angle_x,
    input  wire logic [15:0]        i_angle_y,
    input  wire logic [15:0]        i_angle_z,
    input  wire logic signed [23:0] i_scale_x,
    input  wire logic signed [23:0] i_scale_y,
    input  wire logic signed [23:0] i_scale_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [23:0]      o_m00,
    output logic signed [23:0]      o_m01,
    output logic signed [23:0]      o_m02,
    output logic signed [23:0]      o_m10,
    output logic signed [23:0]      o_m11,
    output logic signed [23:0]      o_m12,
    output logic signed [23:0]      o_m20,
    output logic signed [23:0]      o_m21,
    output logic signed [23:0]      o_m22,
    output logic signed [31:0]      o_trans_x,
    output logic signed [31:0]      o_trans_y,
    output logic signed [31:0]      o_trans_z
);

    logic [etmb_pkg::NSTAGE-1:0] r_valid;
    logic [etmb_pkg::NSTAGE-1:0] w_en;
    etmb_pkg::t_side             r_side [0:etmb_pkg::NSTAGE-1];
    etmb_pkg::t_side             w_side_in;

    logic signed [etmb_pkg::TW-1:0] w_sx, w_cx, w_sy, w_cy, w_sz, w_cz;

    // first stage after the cordic: two-factor products
    logic signed [33:0] r_czcy, r_czsy, r_czcx, r_szsx, r_szcy;
    logic signed [33:0] r_szsy, r_szcx, r_czsx, r_cysx, r_cycx;
    logic signed [etmb_pkg::TW-1:0] r_sx1, r_cx1, r_sy1;
    // triple products
    logic signed [50:0] r_czsysx, r_czsycx, r_szsysx, r_szsycx;
    logic signed [33:0] r_czcy2, r_szcx2, r_szsx2, r_szcy2;
    logic signed [33:0] r_czcx2, r_czsx2, r_cysx2, r_cycx2;
    logic signed [etmb_pkg::TW-1:0] r_sy2;
    // rotation entries in q30
    logic signed [47:0] n_rot [0:8];
    logic signed [47:0] n_rnd [0:8];
    logic signed [32:0] r_e   [0:8];
    // scaled products
    logic signed [56:0] r_prod [0:8];
    // output entries
    logic signed [56:0] n_q    [0:8];
    logic signed [26:0] n_qs   [0:8];
    logic signed [23:0] n_m    [0:8];
    logic signed [23:0] r_m    [0:8];
    logic signed [23:0] w_k    [0:8];

    // a stage may load when it is empty or the stage after it moves
    always_comb begin
        w_en[etmb_pkg::NSTAGE-1] = !r_valid[etmb_pkg::NSTAGE-1] || !i_stall;
        for (int k = etmb_pkg::NSTAGE - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < etmb_pkg::NSTAGE; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_valid[etmb_pkg::NSTAGE-1];

    assign w_side_in = '{pos_x: i_pos_x, pos_y: i_pos_y, pos_z: i_pos_z,
                         scale_x: i_scale_x, scale_y: i_scale_y, scale_z: i_scale_z};

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= w_side_in;
        end
    end

    for (genvar k = 1; k < etmb_pkg::NSTAGE; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    etmb_cordic u_trig_x (
        .i_clk   (i_clk),
        .i_en    (w_en[etmb_pkg::PROD_STAGE-1:0]),
        .i_angle (i_angle_x),
        .o_sin   (w_sx),
        .o_cos   (w_cx)
    );

    etmb_cordic u_trig_y (
        .i_clk   (i_clk),
        .i_en    (w_en[etmb_pkg::PROD_STAGE-1:0]),
        .i_angle (i_angle_y),
        .o_sin   (w_sy),
        .o_cos   (w_cy)
    );

    etmb_cordic u_trig_z (
        .i_clk   (i_clk),
        .i_en    (w_en[etmb_pkg::PROD_STAGE-1:0]),
        .i_angle (i_angle_z),
        .o_sin   (w_sz),
        .o_cos   (w_cz)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[etmb_pkg::PROD_STAGE]) begin
            r_czcy <= 34'(w_cz) * 34'(w_cy);
            r_czsy <= 34'(w_cz) * 34'(w_sy);
            r_czcx <= 34'(w_cz) * 34'(w_cx);
            r_szsx <= 34'(w_sz) * 34'(w_sx);
            r_szcy <= 34'(w_sz) * 34'(w_cy);
            r_szsy <= 34'(w_sz) * 34'(w_sy);
            r_szcx <= 34'(w_sz) * 34'(w_cx);
            r_czsx <= 34'(w_cz) * 34'(w_sx);
            r_cysx <= 34'(w_cy) * 34'(w_sx);
            r_cycx <= 34'(w_cy) * 34'(w_cx);
            r_sx1  <= w_sx;
            r_cx1  <= w_cx;
            r_sy1  <= w_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[etmb_pkg::PROD_STAGE+1]) begin
            r_czsysx <= 51'(r_czsy) * 51'(r_sx1);
            r_czsycx <= 51'(r_czsy) * 51'(r_cx1);
            r_szsysx <= 51'(r_szsy) * 51'(r_sx1);
            r_szsycx <= 51'(r_szsy) * 51'(r_cx1);
            r_czcy2  <= r_czcy;
            r_szcx2  <= r_szcx;
            r_szsx2  <= r_szsx;
            r_szcy2  <= r_szcy;
            r_czcx2  <= r_czcx;
            r_czsx2  <= r_czsx;
            r_cysx2  <= r_cysx;
            r_cycx2  <= r_cycx;
            r_sy2    <= r_sy1;
        end
    end

    // entries in q45, rounded to q30
    always_comb begin
        n_rot[0] = 48'(r_czcy2) <<< 15;
        n_rot[1] = 48'(r_czsysx) - (48'(r_szcx2) <<< 15);
        n_rot[2] = 48'(r_czsycx) + (48'(r_szsx2) <<< 15);
        n_rot[3] = 48'(r_szcy2) <<< 15;
        n_rot[4] = 48'(r_szsysx) + (48'(r_czcx2) <<< 15);
        n_rot[5] = 48'(r_szsycx) - (48'(r_czsx2) <<< 15);
        n_rot[6] = -(48'(r_sy2) <<< 30);
        n_rot[7] = 48'(r_cysx2) <<< 15;
        n_rot[8] = 48'(r_cycx2) <<< 15;
        for (int j = 0; j < 9; j++) begin
            n_rnd[j] = n_rot[j] + 48'sd16384;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[etmb_pkg::PROD_STAGE+2]) begin
            for (int j = 0; j < 9; j++) begin
                r_e[j] <= $signed(n_rnd[j][47:15]);
            end
        end
    end

    // column 0 takes scale x, column 1 scale y, column 2 scale z
    always_comb begin
        for (int j = 0; j < 9; j++) begin
            case (j % 3)
                0:       w_k[j] = r_side[etmb_pkg::PROD_STAGE+2].scale_x;
                1:       w_k[j] = r_side[etmb_pkg::PROD_STAGE+2].scale_y;
                default: w_k[j] = r_side[etmb_pkg::PROD_STAGE+2].scale_z;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[etmb_pkg::PROD_STAGE+3]) begin
            for (int j = 0; j < 9; j++) begin
                r_prod[j] <= 57'(r_e[j]) * 57'(w_k[j]);
            end
        end
    end

    // round q46 to q16 and saturate
    always_comb begin
        for (int j = 0; j < 9; j++) begin
            n_q[j]  = r_prod[j] + 57'sd536870912;
            n_qs[j] = $signed(n_q[j][56:30]);
            if (n_qs[j] > 27'(etmb_pkg::OUT_MAX)) begin
                n_m[j] = etmb_pkg::OUT_MAX;
            end else if (n_qs[j] < 27'(etmb_pkg::OUT_MIN)) begin
                n_m[j] = etmb_pkg::OUT_MIN;
            end else begin
                n_m[j] = n_qs[j][23:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[etmb_pkg::PROD_STAGE+4]) begin
            for (int j = 0; j < 9; j++) begin
                r_m[j] <= n_m[j];
            end
        end
    end

    assign o_m00     = r_m[0];
    assign o_m01     = r_m[1];
    assign o_m02     = r_m[2];
    assign o_m10     = r_m[3];
    assign o_m11     = r_m[4];
    assign o_m12     = r_m[5];
    assign o_m20     = r_m[6];
    assign o_m21     = r_m[7];
    assign o_m22     = r_m[8];
    assign o_trans_x = r_side[etmb_pkg::NSTAGE-1].pos_x;
    assign o_trans_y = r_side[etmb_pkg::NSTAGE-1].pos_y;
    assign o_trans_z = r_side[etmb_pkg::NSTAGE-1].pos_z;

endmodule

`default_nettype wire
